// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define OSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define OSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/osm_pkg.sv -----
package osm_pkg;

  localparam int DISTINCT_ENTRIES = 256;
  localparam int COUNT_BITS       = 20;
  localparam int VALUE_BITS       = 32;   // 8..32 with the 32-bit operand port

  localparam int USED_W  = $clog2(DISTINCT_ENTRIES) + 1;
  localparam int GROUP   = 16;
  localparam int NGROUPS = (DISTINCT_ENTRIES + GROUP - 1) / GROUP;

  localparam logic [63:0] CNT_MAX_L   = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] TOTAL_CAP_L = 64'h7FFF_FFFF;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = COUNT_BITS'(CNT_MAX_L);
  localparam logic [COUNT_BITS-1:0] TOTAL_LIMIT =
    COUNT_BITS'((CNT_MAX_L < TOTAL_CAP_L) ? CNT_MAX_L : TOTAL_CAP_L);
  localparam logic [USED_W-1:0] USED_FULL = USED_W'(DISTINCT_ENTRIES);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_RANK   = 3'd2,
    OP_KTH    = 3'd3,
    OP_PRED   = 3'd4,
    OP_SUCC   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_NONE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_GATH,
    ST_FIN
  } state_t;

  // Cell update applied in the finish cycle.
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_INC,   // extra copy of a held value
    UPD_INS,   // new value, cells from the slot on shift right
    UPD_DEC,   // one copy fewer, entry stays
    UPD_REM    // last copy gone, cells from the slot on shift left
  } upd_t;

  typedef enum logic [1:0] {
    SEL_LAST_LT,   // rank, predecessor
    SEL_FIRST_GT,  // successor
    SEL_FIRST_GEK  // kth
  } sel_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] val;   // offset binary
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] cum;   // copies in this cell and all below
  } cell_data_t;

  typedef struct packed {
    logic                  capture;
    upd_t                  upd;
    sel_t                  sel;
    logic [VALUE_BITS-1:0] key;
    logic [31:0]           k;
  } cell_cmd_t;

  typedef struct packed {
    logic                  any;   // some cell selected
    logic                  eqf;   // value held
    logic                  one;   // held value has one copy
    logic                  sat;   // held value count at its limit
    logic [VALUE_BITS-1:0] val;
    logic [COUNT_BITS-1:0] cum;
  } gather_t;

endpackage

// ----- rtl/osm_cell.sv -----
module osm_cell import osm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  cell_data_t left_d,
  input  cell_data_t right_d,
  input  logic       left_lt,
  input  logic       left_gt,
  input  logic       left_gek,
  input  logic       right_lt,
  output cell_data_t own_d,
  output logic       lt,
  output logic       gt,
  output logic       gek,
  output gather_t    g
);

  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] cum_r, cum_nxt;
  logic lt_r, eq_r, gt_r, gek_r;
  logic occ, sel;

  assign occ   = (cnt_r != '0);
  assign own_d = '{val: val_r, cnt: cnt_r, cum: cum_r};
  assign lt    = lt_r;
  assign gt    = gt_r;
  assign gek   = gek_r;

  always_comb begin
    case (cmd.sel)
      SEL_LAST_LT:   sel = lt_r & ~right_lt;
      SEL_FIRST_GT:  sel = gt_r & ~left_gt;
      SEL_FIRST_GEK: sel = gek_r & ~left_gek;
      default:       sel = 1'b0;
    endcase
    g.any = sel;
    g.eqf = eq_r;
    g.one = eq_r & (cnt_r == COUNT_BITS'(1));
    g.sat = eq_r & (cnt_r == CNT_MAX);
    g.val = sel ? val_r : '0;
    g.cum = sel ? cum_r : '0;
  end

  always_comb begin
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    cum_nxt = cum_r;
    case (cmd.upd)
      UPD_INC: begin
        if (!lt_r) cum_nxt = cum_r + 1'b1;
        if (eq_r)  cnt_nxt = cnt_r + 1'b1;
      end
      UPD_DEC: begin
        if (!lt_r) cum_nxt = cum_r - 1'b1;
        if (eq_r)  cnt_nxt = cnt_r - 1'b1;
      end
      UPD_INS: begin
        if (!lt_r) begin
          if (left_lt) begin
            val_nxt = cmd.key;
            cnt_nxt = COUNT_BITS'(1);
          end else begin
            val_nxt = left_d.val;
            cnt_nxt = left_d.cnt;
          end
          cum_nxt = left_d.cum + 1'b1;
        end
      end
      UPD_REM: begin
        if (!lt_r) begin
          val_nxt = right_d.val;
          cnt_nxt = right_d.cnt;
          cum_nxt = right_d.cum - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cum_r <= cum_nxt;
    if (cmd.capture) begin
      lt_r  <= occ & (val_r < cmd.key);
      eq_r  <= occ & (val_r == cmd.key);
      gt_r  <= occ & (val_r > cmd.key);
      gek_r <= occ & (32'(cum_r) >= cmd.k);
    end
  end

endmodule

// ----- rtl/osm_gather.sv -----
module osm_gather import osm_pkg::*; (
  input  logic    clk,
  input  gather_t g_in [DISTINCT_ENTRIES],
  output gather_t g_out
);

  gather_t grp_r [NGROUPS];
  gather_t grp_nxt [NGROUPS];

  // First level: OR within each group of cells, registered.
  always_comb begin
    for (int j = 0; j < NGROUPS; j++) begin
      grp_nxt[j] = '0;
      for (int i = 0; i < GROUP; i++) begin
        if (j * GROUP + i < DISTINCT_ENTRIES) grp_nxt[j] = grp_nxt[j] | g_in[j * GROUP + i];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  // Second level: OR across groups.
  always_comb begin
    g_out = '0;
    for (int j = 0; j < NGROUPS; j++) g_out = g_out | grp_r[j];
  end

endmodule

// ----- rtl/order_statistic_multiset_top.sv -----
// Channel   Ports                            Handshake
// input     in_kind[2:0], in_operand[31:0]   taken when start && !busy
// result    out_answer[31:0], out_status     out_valid, one cycle, no stall
//
// Each item passes in turn through a compare in every cell, the group OR of the
// cell selections, the final reduction plus cell update, then the result register.
// busy is high in the compare, gather and finish states after an item is taken;
// the next item can be taken in the cycle the result is shown. The receiver cannot stall.
// Reset (rst_n low, synchronous) empties the store: every cell count goes to
// zero, which marks the cell unused. Values are not cleared.
`include "assert_macros.svh"

module order_statistic_multiset_top import osm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_operand,
  output logic               out_valid,
  output logic signed [31:0] out_answer,
  output logic [1:0]         out_status
);

  state_t state_r, state_nxt;

  // Latched item
  logic [2:0]            kind_r;
  logic [VALUE_BITS-1:0] key_r;
  logic [31:0]           k_r;

  // Store occupancy
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] answer_r, answer_nxt;
  status_t     status_r, status_nxt;

  cell_cmd_t  cmd;
  upd_t       upd;
  sel_t       sel;
  gather_t    gsum;
  logic       k_bad;
  logic       accept;

  cell_data_t cdata [DISTINCT_ENTRIES];
  logic       clt   [DISTINCT_ENTRIES];
  logic       cgt   [DISTINCT_ENTRIES];
  logic       cgek  [DISTINCT_ENTRIES];
  gather_t    cg    [DISTINCT_ENTRIES];

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_answer = answer_r;
  assign out_status = status_r;

  // Which cell each query reads from
  always_comb begin
    case (kind_r)
      OP_SUCC: sel = SEL_FIRST_GT;
      OP_KTH:  sel = SEL_FIRST_GEK;
      default: sel = SEL_LAST_LT;
    endcase
  end

  assign cmd = '{capture: (state_r == ST_CMP), upd: upd, sel: sel, key: key_r, k: k_r};

  // Row of cells; cell 0 sees an empty "below" neighbor that counts as less,
  // the top cell sees an empty "above" neighbor.
  for (genvar i = 0; i < DISTINCT_ENTRIES; i++) begin : g_cell
    cell_data_t ld, rd;
    logic       llt, lgt, lgek, rlt;
    if (i == 0) begin : g_lo
      assign ld   = '0;
      assign llt  = 1'b1;
      assign lgt  = 1'b0;
      assign lgek = 1'b0;
    end else begin : g_mid_lo
      assign ld   = cdata[i-1];
      assign llt  = clt[i-1];
      assign lgt  = cgt[i-1];
      assign lgek = cgek[i-1];
    end
    if (i == DISTINCT_ENTRIES - 1) begin : g_hi
      assign rd  = '0;
      assign rlt = 1'b0;
    end else begin : g_mid_hi
      assign rd  = cdata[i+1];
      assign rlt = clt[i+1];
    end
    osm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .left_d   (ld),
      .right_d  (rd),
      .left_lt  (llt),
      .left_gt  (lgt),
      .left_gek (lgek),
      .right_lt (rlt),
      .own_d    (cdata[i]),
      .lt       (clt[i]),
      .gt       (cgt[i]),
      .gek      (cgek[i]),
      .g        (cg[i])
    );
  end

  osm_gather u_gather (
    .clk   (clk),
    .g_in  (cg),
    .g_out (gsum)
  );

  assign k_bad = (k_r == '0) || k_r[31] || (k_r > 32'(total_r));

  // Control: next state, result and store update in the finish cycle
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    answer_nxt    = answer_r;
    status_nxt    = status_r;
    upd           = UPD_NONE;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_GATH;
      ST_GATH: state_nxt = ST_FIN;
      ST_FIN: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        answer_nxt    = '0;
        status_nxt    = STAT_OK;
        case (kind_r)
          OP_INSERT: begin
            if (total_r >= TOTAL_LIMIT) begin
              status_nxt = STAT_FULL;
            end else if (gsum.eqf) begin
              if (gsum.sat) status_nxt = STAT_FULL;
              else begin
                upd       = UPD_INC;
                total_nxt = total_r + 1'b1;
              end
            end else if (used_r == USED_FULL) begin
              status_nxt = STAT_FULL;
            end else begin
              upd       = UPD_INS;
              total_nxt = total_r + 1'b1;
              used_nxt  = used_r + 1'b1;
            end
          end
          OP_DELETE: begin
            if (!gsum.eqf) begin
              status_nxt = STAT_ABSENT;
            end else begin
              total_nxt = total_r - 1'b1;
              if (gsum.one) begin
                upd      = UPD_REM;
                used_nxt = used_r - 1'b1;
              end else begin
                upd = UPD_DEC;
              end
            end
          end
          OP_RANK: answer_nxt = 32'(gsum.cum) + 32'd1;
          OP_KTH, OP_PRED, OP_SUCC: begin
            if ((kind_r == OP_KTH && k_bad) || !gsum.any) begin
              status_nxt = STAT_NONE;
            end else begin
              // offset binary back to two's complement
              answer_nxt = 32'({~gsum.val[VALUE_BITS-1], gsum.val[VALUE_BITS-2:0]});
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    answer_r <= answer_nxt;
    status_r <= status_nxt;
    if (accept) begin
      kind_r <= in_kind;
      key_r  <= {~in_operand[VALUE_BITS-1], in_operand[VALUE_BITS-2:0]};
      k_r    <= in_operand;
    end
  end

  // Every taken item yields its result on out_valid.
  `OSM_ASSERT_NOW(a_latency, clk, rst_n, accept, ##4 out_valid, "result missing after item")
  // A result only shows once the block is free again.
  `OSM_ASSERT_NOW(a_valid_idle, clk, rst_n, out_valid, !busy, "result while busy")
  // Each used entry holds at least one copy.
  `OSM_ASSERT_NOW(a_occupancy, clk, rst_n, 1'b1,
    (32'(used_r) <= 32'(total_r)) && (used_r <= USED_FULL), "occupancy counters disagree")
  // Store changes only in the finish cycle.
  `OSM_ASSERT_NEXT(a_total_hold, clk, rst_n, state_r != ST_FIN, $stable(total_r),
    "element total changed outside update")

endmodule
